@@ src/payload_field_extractor_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the payload field extractor
// Concurrent checks clocked on clk with reset rst_n; empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef PAYLOAD_FIELD_EXTRACTOR_UNIT_MACROS_SVH
`define PAYLOAD_FIELD_EXTRACTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PFE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PFE_ASSERT_SAME(label, ante, cons, msg)
`define PFE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ src/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and codes of the payload field extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfe_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_WINDOW_OFFSET = 3'd0;
  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd1;
  localparam logic [2:0] REG_TO_END        = 3'd2;
  localparam logic [2:0] REG_DECODE_KIND   = 3'd3;
  localparam logic [2:0] REG_LITTLE_ENDIAN = 3'd4;
  localparam logic [2:0] REG_SLICE_OFFSET  = 3'd5;
  localparam logic [2:0] REG_SLICE_LENGTH  = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  // Decode kinds; the unused codes decode as unsigned.
  localparam logic [2:0] KIND_UNSIGNED = 3'd0;
  localparam logic [2:0] KIND_SIGNED   = 3'd1;
  localparam logic [2:0] KIND_SLICE    = 3'd2;
  localparam logic [2:0] KIND_FLOAT32  = 3'd3;
  localparam logic [2:0] KIND_FLOAT64  = 3'd4;

  // Result error codes.
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_RANGE     = 3'd1,
    ERR_BIT_RANGE = 3'd2,
    ERR_UINT_LEN  = 3'd3,
    ERR_INT_LEN   = 3'd4,
    ERR_FLOAT_LEN = 3'd5,
    ERR_NONFINITE = 3'd6
  } err_t;

  // Live configuration.
  typedef struct packed {
    logic [12:0] window_offset;
    logic [12:0] window_length;
    logic        to_end;
    logic [2:0]  decode_kind;
    logic        little_endian;
    logic [14:0] slice_offset;
    logic [6:0]  slice_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    window_offset: 13'd0,
    window_length: 13'd1,
    to_end:        1'b1,
    decode_kind:   3'd0,
    little_endian: 1'b0,
    slice_offset:  15'd0,
    slice_length:  7'd0
  };

endpackage

@@ src/pfe_accum.sv @@
// ----------------------------------------------------------------------------
// pfe_accum
// Window assembly: counts payload beats, gathers window bytes into 64 bits
// and hands the finished payload to a holding register at the last beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_accum #(
  parameter int MAX_PAYLOAD = 4096,
  parameter int IDX_W       = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfe_pkg::cfg_t         cfg,
  input  logic                  beat,
  input  logic [7:0]            payload_byte,
  input  logic                  last_byte,
  input  logic                  fin_take,
  output logic                  fin_valid_r,
  output logic [63:0]           fin_raw_r,
  output logic [IDX_W-1:0]      fin_size_r
);

  localparam int LW = ((IDX_W > 13) ? IDX_W : 13) + 1;

  logic [IDX_W-1:0] idx_r, idx_nxt, idx_upd;
  logic [63:0]      asm_r, asm_nxt, asm_upd;
  logic             fin_valid_nxt;
  logic [LW-1:0]    pos_x, wo_x, rel;
  logic             room, in_win;

  // Window membership of the current byte position.
  assign room   = idx_r < IDX_W'(MAX_PAYLOAD);
  assign pos_x  = LW'(idx_r);
  assign wo_x   = LW'(cfg.window_offset);
  assign rel    = pos_x - wo_x;
  assign in_win = (pos_x >= wo_x) && (cfg.to_end || (rel < LW'(cfg.window_length)));

  // Byte placement and the saturating count.
  always_comb begin
    asm_upd = asm_r;
    if (room && in_win) begin
      if (cfg.little_endian) begin
        if (rel < LW'(8)) begin
          asm_upd = asm_r | (64'(payload_byte) << {rel[2:0], 3'b000});
        end
      end else begin
        asm_upd = {asm_r[55:0], payload_byte};
      end
    end
    idx_upd = room ? idx_r + IDX_W'(1) : idx_r;
  end

  // State and holding register next values.
  always_comb begin
    idx_nxt       = idx_r;
    asm_nxt       = asm_r;
    fin_valid_nxt = fin_valid_r && !fin_take;
    if (beat) begin
      if (last_byte) begin
        idx_nxt       = '0;
        asm_nxt       = '0;
        fin_valid_nxt = 1'b1;
      end else begin
        idx_nxt = idx_upd;
        asm_nxt = asm_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      asm_r       <= '0;
      fin_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      asm_r       <= asm_nxt;
      fin_valid_r <= fin_valid_nxt;
    end
  end

  // Finished payload data; no reset needed.
  always_ff @(posedge clk) begin
    if (beat && last_byte) begin
      fin_raw_r  <= asm_upd;
      fin_size_r <= idx_upd;
    end
  end

endmodule

@@ src/pfe_decode.sv @@
// ----------------------------------------------------------------------------
// pfe_decode
// Range and length checks and decoding of an assembled window into the
// field value and error code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_decode #(
  parameter int IDX_W = 13
) (
  input  pfe_pkg::cfg_t     cfg,
  input  logic [63:0]       raw,
  input  logic [IDX_W-1:0]  size,
  output logic [63:0]       value,
  output pfe_pkg::err_t     err
);

  localparam int LW = ((IDX_W > 13) ? IDX_W : 13) + 1;
  localparam int SW = (((LW + 3) > 16) ? (LW + 3) : 16) + 1;

  logic [LW-1:0] size_x, wo_x, span, len;
  logic          range_bad, len_gt8;
  logic [6:0]    len_bits;
  logic [63:0]   sext;
  logic [SW-1:0] slice_end, win_bits;
  logic          slice_bad;
  logic [63:0]   slice_mask, slice_val;

  // Window length and range check.
  assign size_x    = LW'(size);
  assign wo_x      = LW'(cfg.window_offset);
  assign span      = size_x - wo_x;
  assign len       = cfg.to_end ? span : LW'(cfg.window_length);
  assign range_bad = (wo_x > size_x) || (len == '0) || (len > span);
  assign len_gt8   = len > LW'(8);

  // Sign extension for windows shorter than 8 bytes.
  assign len_bits = {len[3:0], 3'b000};
  always_comb begin
    sext = raw;
    if (!len_gt8 && (len[3:0] != 4'd8) && raw[6'(len_bits - 7'd1)]) begin
      sext = raw | ({64{1'b1}} << len_bits[5:0]);
    end
  end

  // Bit slice bounds and extraction.
  assign slice_end  = SW'(cfg.slice_offset) + SW'(cfg.slice_length);
  assign win_bits   = SW'(len) << 3;
  assign slice_bad  = (cfg.slice_length == 7'd0) || (cfg.slice_length > 7'd64) ||
                      (slice_end > win_bits);
  assign slice_mask = (cfg.slice_length == 7'd64) ? {64{1'b1}} :
                      ((64'd1 << cfg.slice_length[5:0]) - 64'd1);
  assign slice_val  = (|cfg.slice_offset[14:6]) ? 64'd0 :
                      ((raw >> cfg.slice_offset[5:0]) & slice_mask);

  // Selection by decode kind; any error forces the value to zero.
  always_comb begin
    value = 64'd0;
    err   = pfe_pkg::ERR_OK;
    if (range_bad) begin
      err = pfe_pkg::ERR_RANGE;
    end else begin
      case (cfg.decode_kind)
        pfe_pkg::KIND_SIGNED: begin
          if (len_gt8) err = pfe_pkg::ERR_INT_LEN;
          else value = sext;
        end
        pfe_pkg::KIND_SLICE: begin
          if (slice_bad) err = pfe_pkg::ERR_BIT_RANGE;
          else value = slice_val;
        end
        pfe_pkg::KIND_FLOAT32: begin
          if (len != LW'(4)) err = pfe_pkg::ERR_FLOAT_LEN;
          else if (&raw[30:23]) err = pfe_pkg::ERR_NONFINITE;
          else value = {32'd0, raw[31:0]};
        end
        pfe_pkg::KIND_FLOAT64: begin
          if (len != LW'(8)) err = pfe_pkg::ERR_FLOAT_LEN;
          else if (&raw[62:52]) err = pfe_pkg::ERR_NONFINITE;
          else value = raw;
        end
        default: begin
          if (len_gt8) err = pfe_pkg::ERR_UINT_LEN;
          else value = raw;
        end
      endcase
    end
  end

endmodule

@@ src/payload_field_extractor_unit.sv @@
// After its last payload beat is accepted, a result passes through the holding register, then the result register.
// Throughput: one payload beat per cycle while in_stall is low.
// A stalled result is held while the next payload keeps streaming in.
// Reset (rst_n low, synchronous): the configuration returns to its reset values,
// the byte count and assembled value clear and no result is pending.
// ----------------------------------------------------------------------------
// payload_field_extractor_unit
// Streaming extractor that cuts a byte window from a payload and decodes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "payload_field_extractor_unit_macros.svh"

module payload_field_extractor_unit #(
  parameter int MAX_PAYLOAD = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_payload_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [63:0]                       out_field_value,
  output logic [2:0]                        out_error_code
);

  localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

  pfe_pkg::cfg_t    cfg_r, cfg_nxt;
  logic             beat, fin_take, fin_valid;
  logic [63:0]      fin_raw;
  logic [IDX_W-1:0] fin_size;
  logic [63:0]      dec_value;
  pfe_pkg::err_t    dec_err;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_value_r;
  pfe_pkg::err_t    out_err_r;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        pfe_pkg::REG_WINDOW_OFFSET: cfg_nxt.window_offset = cfg_wdata[12:0];
        pfe_pkg::REG_WINDOW_LENGTH: cfg_nxt.window_length = cfg_wdata[12:0];
        pfe_pkg::REG_TO_END:        cfg_nxt.to_end        = cfg_wdata[0];
        pfe_pkg::REG_DECODE_KIND:   cfg_nxt.decode_kind   = cfg_wdata[2:0];
        pfe_pkg::REG_LITTLE_ENDIAN: cfg_nxt.little_endian = cfg_wdata[0];
        pfe_pkg::REG_SLICE_OFFSET:  cfg_nxt.slice_offset  = cfg_wdata[14:0];
        pfe_pkg::REG_SLICE_LENGTH:  cfg_nxt.slice_length  = cfg_wdata[6:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Handshake: the holding register drains into the result register.
  assign fin_take = fin_valid && (!out_valid_r || !out_stall);
  assign in_stall = fin_valid && !fin_take;
  assign beat     = in_valid && !in_stall;

  pfe_accum #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IDX_W       (IDX_W)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .beat         (beat),
    .payload_byte (in_payload_byte),
    .last_byte    (in_last_byte),
    .fin_take     (fin_take),
    .fin_valid_r  (fin_valid),
    .fin_raw_r    (fin_raw),
    .fin_size_r   (fin_size)
  );

  pfe_decode #(
    .IDX_W (IDX_W)
  ) u_decode (
    .cfg   (cfg_r),
    .raw   (fin_raw),
    .size  (fin_size),
    .value (dec_value),
    .err   (dec_err)
  );

  // Result register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_take) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= pfe_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_value_r <= dec_value;
      out_err_r   <= dec_err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_value = out_value_r;
  assign out_error_code  = out_err_r;

  // Checks on the result path.
  `PFE_ASSERT_SAME(a_err_zero_value, out_valid_r && (out_err_r != pfe_pkg::ERR_OK), out_value_r == 64'd0, "error result with nonzero value")
  `PFE_ASSERT_NEXT(a_last_held, beat && in_last_byte, fin_valid, "last beat did not reach holding register")
  `PFE_ASSERT_SAME(a_rise_from_fin, $rose(out_valid_r), $past(fin_valid), "result appeared without a finished payload")
  `PFE_ASSERT_SAME(a_err_code_legal, out_valid_r, out_error_code != 3'd7, "undefined error code")

endmodule
